### rtl/sch_pkg.sv
// Types and constants shared by the sensor channel health reader.
`default_nettype none

package sch_pkg;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_CHANNEL  = 3'd1,
    ST_NOT_ATTACHED = 3'd2,
    ST_BACKOFF      = 3'd3,
    ST_READ_FAILED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_ATTACHED_MASK  = 2'd0,
    CFG_FAIL_LIMIT     = 2'd1,
    CFG_RETRY_INTERVAL = 2'd2
  } cfg_idx_e;

  localparam logic [3:0]         FailLimitRst     = 4'd3;
  localparam logic [31:0]        RetryIntervalRst = 32'd60000000;
  localparam logic signed [15:0] TempInvalid      = 16'sh8000;

  typedef struct packed {
    logic [1:0]  channel;
    logic [47:0] now_us;
    logic        read_ok;
    logic [15:0] raw_word;
  } in_word_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [15:0] temp_x100;
    status_e            status;
    logic               present_now;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/sch_temp_conv.sv
// Raw 1/128 degree reading to hundredths of a degree with symmetric rounding.
`default_nettype none

module sch_temp_conv (
  input  logic [15:0]        raw_i,
  output logic signed [15:0] temp_o
);

  logic signed [21:0] raw_ext;
  logic signed [21:0] scaled;
  logic signed [21:0] biased;

  always_comb begin
    raw_ext = 22'(signed'(raw_i));
    scaled  = raw_ext * 22'sd25 + (raw_i[15] ? -22'sd16 : 22'sd16);
    // Add 31 before the shift so negative values truncate toward zero.
    biased  = scaled[21] ? scaled + 22'sd31 : scaled;
    temp_o  = 16'(biased >>> 5);
  end

endmodule

`default_nettype wire

### rtl/sensor_channel_health_reader.sv
// Top level of the sensor channel health reader.
//
//   channel  direction  handshake                 word
//   config   in         cfg_we_i                  cfg_idx_i, cfg_data_i
//   input    in         in_valid_i / in_ready_o   in_word_i
//   result   out        out_valid_o / out_ready_i out_word_o
//
// One word per cycle sustained while out_ready_i is high; an accepted input word waits in
// the input register and moves to the result register once that register is free or taken.
// The channel state is read and written in the single step between the two registers.
// Reset clears all channel state; configuration returns to its reset values.
// A stalled result holds while one more input word waits in the input register.
`default_nettype none

module sensor_channel_health_reader #(
  parameter int CHANNELS = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sch_pkg::in_word_t  in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sch_pkg::out_word_t out_word_o
);
  import sch_pkg::*;

  localparam logic [2:0] ChLimit = 3'(CHANNELS);

  logic [1:0]  attached_q;
  logic [3:0]  limit_q;
  logic [31:0] interval_q;

  logic        present_q  [CHANNELS];
  logic [3:0]  count_q    [CHANNELS];
  logic [47:0] deadline_q [CHANNELS];

  in_word_t  in_q;
  logic      in_vld_q;
  out_word_t out_q;
  logic      out_vld_q;

  logic        advance;
  logic        ch_ok;
  logic        attached;
  logic        cur_pres;
  logic [3:0]  cur_cnt;
  logic [47:0] cur_dl;
  logic [3:0]  cnt_inc;
  logic [47:0] dl_sum;
  logic        pres_d;
  logic [3:0]  cnt_d;
  logic [47:0] dl_d;
  logic        upd;
  out_word_t   out_d;
  logic signed [15:0] temp_conv;

  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  sch_temp_conv u_temp_conv (
    .raw_i  (in_q.raw_word),
    .temp_o (temp_conv)
  );

  always_comb begin
    cur_pres = 1'b0;
    cur_cnt  = '0;
    cur_dl   = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (in_q.channel == 2'(c)) begin
        cur_pres = present_q[c];
        cur_cnt  = count_q[c];
        cur_dl   = deadline_q[c];
      end
    end

    ch_ok    = {1'b0, in_q.channel} < ChLimit;
    attached = !in_q.channel[1] && attached_q[in_q.channel[0]];
    cnt_inc  = (cur_cnt < limit_q) ? cur_cnt + 4'd1 : cur_cnt;
    dl_sum   = in_q.now_us + {16'b0, interval_q};

    pres_d = cur_pres;
    cnt_d  = cur_cnt;
    dl_d   = cur_dl;
    upd    = 1'b0;

    out_d.valid_res   = 1'b0;
    out_d.temp_x100   = TempInvalid;
    out_d.present_now = 1'b0;
    out_d.status      = ST_OK;

    if (!ch_ok) begin
      out_d.status = ST_BAD_CHANNEL;
    end else if (!attached) begin
      out_d.status      = ST_NOT_ATTACHED;
      out_d.present_now = cur_pres;
    end else if (!cur_pres && (in_q.now_us < cur_dl)) begin
      out_d.status = ST_BACKOFF;
    end else if (!in_q.read_ok) begin
      upd   = 1'b1;
      cnt_d = cnt_inc;
      if (cnt_inc >= limit_q && cur_pres) begin
        pres_d = 1'b0;
        dl_d   = dl_sum;
      end else if (!cur_pres) begin
        dl_d   = dl_sum;
      end
      out_d.status      = ST_READ_FAILED;
      out_d.present_now = pres_d;
    end else begin
      upd               = 1'b1;
      pres_d            = 1'b1;
      cnt_d             = '0;
      out_d.valid_res   = 1'b1;
      out_d.temp_x100   = temp_conv;
      out_d.present_now = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attached_q <= '0;
      limit_q    <= FailLimitRst;
      interval_q <= RetryIntervalRst;
      for (int c = 0; c < CHANNELS; c++) begin
        present_q[c]  <= 1'b0;
        count_q[c]    <= '0;
        deadline_q[c] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATTACHED_MASK: begin
          attached_q <= cfg_data_i[1:0];
          for (int c = 0; c < CHANNELS; c++) begin
            present_q[c]  <= (c < 2) ? cfg_data_i[c] : 1'b0;
            count_q[c]    <= '0;
            deadline_q[c] <= '0;
          end
        end
        CFG_FAIL_LIMIT:     limit_q    <= cfg_data_i[3:0];
        CFG_RETRY_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end else if (advance && upd) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (in_q.channel == 2'(c)) begin
          present_q[c]  <= pres_d;
          count_q[c]    <= cnt_d;
          deadline_q[c] <= dl_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

### rtl/sch_chk.sv
// Port-level checks for the sensor channel health reader and their bind.
`default_nettype none

module sch_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sch_pkg::out_word_t out_word_o
);
  import sch_pkg::*;

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.valid_res == (out_word_o.status == ST_OK))
    else $error("valid_res disagrees with status");

  a_invalid_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.valid_res |-> out_word_o.temp_x100 == TempInvalid)
    else $error("invalid result without invalid temperature code");

  a_ok_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_OK || out_word_o.status == ST_BAD_CHANNEL ||
                    out_word_o.status == ST_BACKOFF)
    |-> out_word_o.present_now == (out_word_o.status == ST_OK))
    else $error("present_now inconsistent with status");

endmodule

bind sensor_channel_health_reader sch_chk u_sch_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
